FILE: rtl/look_at_view_matrix_unit_defines.svh
// Assertion macros shared by the view matrix RTL.
// Include by bare file name; each macro expects i_clk and i_rst_n in scope.
`ifndef LOOK_AT_VIEW_MATRIX_UNIT_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LVM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lvm_pkg.sv
// Shared types and constants for the look-at view matrix unit.
// No dependencies; imported by lvm_norm and look_at_view_matrix_unit.
package lvm_pkg;

    localparam int DATA_W     = 32;
    localparam int VEC_W      = 64;
    localparam int M_W        = 31;
    localparam int LEN_W      = 32;
    localparam int SQRT_STEPS = 32;
    localparam int ROW_W      = 2;

    localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
    localparam logic [ROW_W-1:0] ROW_LAST  = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] eye_x;
        logic signed [DATA_W-1:0] eye_y;
        logic signed [DATA_W-1:0] eye_z;
        logic signed [DATA_W-1:0] target_x;
        logic signed [DATA_W-1:0] target_y;
        logic signed [DATA_W-1:0] target_z;
        logic signed [DATA_W-1:0] up_x;
        logic signed [DATA_W-1:0] up_y;
        logic signed [DATA_W-1:0] up_z;
    } t_req;

    typedef struct packed {
        logic [ROW_W-1:0]         row_index;
        logic signed [DATA_W-1:0] col_0;
        logic signed [DATA_W-1:0] col_1;
        logic signed [DATA_W-1:0] col_2;
        logic signed [DATA_W-1:0] col_3;
        logic                     last_row;
    } t_row;

endpackage

FILE: rtl/lvm_norm.sv
// Pipelined 3-vector normalizer: abs/max, leading-one shift, sum of squares,
// bit-per-stage square root and bit-per-stage divide. Depends on lvm_pkg.
module lvm_norm
    import lvm_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [VEC_W-1:0]     i_vec [3],
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic signed [FRAC_BITS+1:0] o_vec [3],
    output logic [SIDE_W-1:0]           o_side
);

    localparam int NW    = FRAC_BITS + 2;
    localparam int QW    = FRAC_BITS + 1;
    localparam int SQ_W  = 2 * M_W;
    localparam int R2_W  = LEN_W + 1;
    localparam int SQ_N  = SQRT_STEPS;
    localparam int S_DIV = 6 + SQ_N;
    localparam int NST   = S_DIV + QW + 1;

    logic [NST-1:0]    r_vld;
    logic [SIDE_W-1:0] r_side [NST];
    logic [3:0]        r_flg  [NST-1];

    logic [VEC_W-1:0] a_mag [3];
    logic [VEC_W-1:0] a_mx;
    logic [3:0]       a_flg;

    logic [VEC_W-1:0] r_sh_mag [4][3];
    logic [VEC_W-1:0] r_sh_mx  [3];

    logic [M_W-1:0]   m4 [3];
    logic [M_W-1:0]   r_m4 [3];
    logic [SQ_W-1:0]  r_sq [3];
    logic [VEC_W-1:0] r_sum;

    logic [M_W-1:0]   r_mc [SQ_N+1][3];
    logic [VEC_W-1:0] r_sn [SQ_N-1];
    logic [VEC_W-1:0] r_sr [SQ_N];

    logic [LEN_W-1:0] r_dr [QW-1][3];
    logic [LEN_W-1:0] r_dl [QW-1];
    logic [QW-1:0]    r_dq [QW][3];

    logic signed [NW-1:0] r_out [3];

    // flags: bit 3 zero vector, bits 2..0 component signs
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_mag[i] = i_vec[i][VEC_W-1] ? unsigned'(-i_vec[i]) : unsigned'(i_vec[i]);
        end
        a_mx = a_mag[0];
        if (a_mag[1] > a_mx) a_mx = a_mag[1];
        if (a_mag[2] > a_mx) a_mx = a_mag[2];
        a_flg = {(a_mx == '0), i_vec[2][VEC_W-1], i_vec[1][VEC_W-1], i_vec[0][VEC_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < NST; k++) r_side[k] <= r_side[k-1];
            r_flg[0] <= a_flg;
            for (int k = 1; k < NST - 1; k++) r_flg[k] <= r_flg[k-1];
            r_sh_mag[0] <= a_mag;
            r_sh_mx[0]  <= a_mx;
        end
    end

    // left-justify the largest magnitude to bit 63, two binary steps per stage
    for (genvar k = 1; k <= 3; k++) begin : g_shift
        localparam int SH1 = VEC_W >> (2 * k - 1);
        localparam int SH2 = SH1 / 2;
        logic             z1, z2;
        logic [VEC_W-1:0] mx1, mx2;
        logic [VEC_W-1:0] mg1 [3];
        logic [VEC_W-1:0] mg2 [3];

        always_comb begin
            z1  = (r_sh_mx[k-1][VEC_W-1 -: SH1] == '0);
            mx1 = z1 ? (r_sh_mx[k-1] << SH1) : r_sh_mx[k-1];
            z2  = (mx1[VEC_W-1 -: SH2] == '0);
            mx2 = z2 ? (mx1 << SH2) : mx1;
            for (int i = 0; i < 3; i++) begin
                mg1[i] = z1 ? (r_sh_mag[k-1][i] << SH1) : r_sh_mag[k-1][i];
                mg2[i] = z2 ? (mg1[i] << SH2) : mg1[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) r_sh_mag[k] <= mg2;
        end

        if (k < 3) begin : g_mx
            always_ff @(posedge i_clk) begin
                if (i_en) r_sh_mx[k] <= mx2;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) m4[i] = r_sh_mag[3][i][VEC_W-1 -: M_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m4[i] <= m4[i];
                r_sq[i] <= SQ_W'(m4[i]) * SQ_W'(m4[i]);
            end
            r_sum   <= VEC_W'(r_sq[0]) + VEC_W'(r_sq[1]) + VEC_W'(r_sq[2]);
            r_mc[0] <= r_m4;
        end
    end

    // floor square root, one result bit per stage
    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        localparam logic [VEC_W-1:0] BIT = VEC_W'(1) << (2 * (SQ_N - 1 - j));
        logic [VEC_W-1:0] n_in, r_in, trial, n_nx, r_nx;

        if (j == 0) begin : g_first
            assign n_in = r_sum;
            assign r_in = '0;
        end else begin : g_rest
            assign n_in = r_sn[j-1];
            assign r_in = r_sr[j-1];
        end

        always_comb begin
            trial = r_in + BIT;
            if (n_in >= trial) begin
                n_nx = n_in - trial;
                r_nx = (r_in >> 1) + BIT;
            end else begin
                n_nx = n_in;
                r_nx = r_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sr[j]   <= r_nx;
                r_mc[j+1] <= r_mc[j];
            end
        end

        if (j < SQ_N - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) r_sn[j] <= n_nx;
            end
        end
    end

    // restoring divide of (m << FRAC_BITS) by length, one quotient bit per stage
    for (genvar d = 0; d < QW; d++) begin : g_div
        logic [LEN_W-1:0] len_in;
        logic [R2_W-1:0]  r2 [3];
        logic [QW-1:0]    q_in [3];
        logic             ge [3];
        logic [LEN_W-1:0] rem_nx [3];
        logic [QW-1:0]    q_nx [3];

        if (d == 0) begin : g_first
            always_comb begin
                len_in = r_sr[SQ_N-1][LEN_W-1:0];
                for (int i = 0; i < 3; i++) begin
                    r2[i]   = R2_W'(r_mc[SQ_N][i]);
                    q_in[i] = '0;
                end
            end
        end else begin : g_rest
            always_comb begin
                len_in = r_dl[d-1];
                for (int i = 0; i < 3; i++) begin
                    r2[i]   = {r_dr[d-1][i], 1'b0};
                    q_in[i] = r_dq[d-1][i];
                end
            end
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                ge[i]     = (r2[i] >= {1'b0, len_in});
                rem_nx[i] = ge[i] ? LEN_W'(r2[i] - {1'b0, len_in}) : LEN_W'(r2[i]);
                q_nx[i]   = {q_in[i][QW-2:0], ge[i]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) r_dq[d] <= q_nx;
        end

        if (d < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dr[d] <= rem_nx;
                    r_dl[d] <= len_in;
                end
            end
        end
    end

    // apply signs; a zero vector gives zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_flg[NST-2][3]) begin
                    r_out[i] <= '0;
                end else if (r_flg[NST-2][i]) begin
                    r_out[i] <= -signed'(NW'(r_dq[QW-1][i]));
                end else begin
                    r_out[i] <= signed'(NW'(r_dq[QW-1][i]));
                end
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_side  = r_side[NST-1];
    assign o_vec   = r_out;

endmodule

FILE: rtl/look_at_view_matrix_unit.sv
// Pipelined: a new request can enter while earlier ones are still in flight.
// Each request gives four rows on the result port, and the pipeline advances
// only when that port holds no matrix or is taking the last row of one.
// Reset: synchronous, active low; clears valid bits and the row counter.
// Depends on lvm_pkg, lvm_norm and look_at_view_matrix_unit_defines.svh.
`include "look_at_view_matrix_unit_defines.svh"

module look_at_view_matrix_unit
    import lvm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_row o_res
);

    localparam int NW    = FRAC_BITS + 2;
    localparam int PW    = DATA_W + NW;
    localparam int CW    = PW + 1;
    localparam int PW2   = 2 * NW;
    localparam int CW2   = PW2 + 1;
    localparam int DW    = PW + 2;
    localparam int SIDE1 = 6 * DATA_W;
    localparam int SIDE2 = 3 * DATA_W + 3 * NW;
    localparam int SIDE3 = 3 * DATA_W + 6 * NW;

    localparam logic [DW-1:0] DOT_HALF = DW'(1) << (FRAC_BITS - 1);
    localparam logic [DW-1:0] SAT_N    = DW'(64'h0000_0000_8000_0000);
    localparam logic [DW-1:0] SAT_P    = DW'(64'h0000_0000_7FFF_FFFF);
    localparam logic [DATA_W-1:0] ONE  = DATA_W'(1) << FRAC_BITS;

    logic en;

    // entry
    logic [2:0][DATA_W-1:0] e_eye, e_tgt, e_up;
    logic                   r_e_vld;
    logic [2:0][DATA_W:0]   r_e_diff;
    logic [2:0][DATA_W-1:0] r_e_eye, r_e_up;

    // first normalize
    logic signed [VEC_W-1:0] n1_in [3];
    logic signed [NW-1:0]    n1_vec [3];
    logic                    n1_vld;
    logic [SIDE1-1:0]        n1_side;
    logic [2:0][DATA_W-1:0]  s1_eye, s1_up;
    logic [2:0][NW-1:0]      n1_dir;

    logic                    r_c1_vld;
    logic signed [PW-1:0]    r_c1_p [6];
    logic [2:0][DATA_W-1:0]  r_c1_eye;
    logic [2:0][NW-1:0]      r_c1_dir;
    logic signed [PW-1:0]    c1_a [3];
    logic signed [PW-1:0]    c1_b [3];

    logic                    r_c2_vld;
    logic signed [CW-1:0]    r_c2_t [3];
    logic [2:0][DATA_W-1:0]  r_c2_eye;
    logic [2:0][NW-1:0]      r_c2_dir;

    // second normalize
    logic signed [VEC_W-1:0] n2_in [3];
    logic signed [NW-1:0]    n2_vec [3];
    logic                    n2_vld;
    logic [SIDE2-1:0]        n2_side;
    logic [2:0][DATA_W-1:0]  s2_eye;
    logic [2:0][NW-1:0]      s2_dir, n2_rt;

    logic                    r_c3_vld;
    logic signed [PW2-1:0]   r_c3_p [6];
    logic [2:0][DATA_W-1:0]  r_c3_eye;
    logic [2:0][NW-1:0]      r_c3_dir, r_c3_rt;
    logic signed [PW2-1:0]   c3_a [3];
    logic signed [PW2-1:0]   c3_b [3];

    logic                    r_c4_vld;
    logic signed [CW2-1:0]   r_c4_t [3];
    logic [2:0][DATA_W-1:0]  r_c4_eye;
    logic [2:0][NW-1:0]      r_c4_dir, r_c4_rt;

    // third normalize
    logic signed [VEC_W-1:0] n3_in [3];
    logic signed [NW-1:0]    n3_vec [3];
    logic                    n3_vld;
    logic [SIDE3-1:0]        n3_side;
    logic [2:0][DATA_W-1:0]  s3_eye;
    logic [2:0][NW-1:0]      s3_dir, s3_rt, n3_tu;
    logic [2:0][NW-1:0]      bas [3];

    logic                    r_d1_vld;
    logic signed [PW-1:0]    r_d1_p [3][3];
    logic [2:0][NW-1:0]      r_d1_rt, r_d1_tu, r_d1_dir;

    logic signed [DW-1:0]    dsum [3];
    logic [DW-1:0]           dmag [3];
    logic [DW-1:0]           drnd [3];
    logic [2:0][DATA_W-1:0]  d_tr;

    logic                    r_d2_vld;
    logic [2:0][DATA_W-1:0]  r_d2_tr;
    logic [2:0][NW-1:0]      r_d2_rt, r_d2_tu, r_d2_dir;
    logic [ROW_W-1:0]        r_row;

    // advance the whole pipe only when the row port can take a new matrix
    assign en      = !r_d2_vld || (!i_stall && (r_row == ROW_LAST));
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld  <= 1'b0;
            r_c1_vld <= 1'b0;
            r_c2_vld <= 1'b0;
            r_c3_vld <= 1'b0;
            r_c4_vld <= 1'b0;
            r_d1_vld <= 1'b0;
            r_d2_vld <= 1'b0;
        end else if (en) begin
            r_e_vld  <= i_valid;
            r_c1_vld <= n1_vld;
            r_c2_vld <= r_c1_vld;
            r_c3_vld <= n2_vld;
            r_c4_vld <= r_c3_vld;
            r_d1_vld <= n3_vld;
            r_d2_vld <= r_d1_vld;
        end
    end

    assign e_eye = {i_req.eye_z, i_req.eye_y, i_req.eye_x};
    assign e_tgt = {i_req.target_z, i_req.target_y, i_req.target_x};
    assign e_up  = {i_req.up_z, i_req.up_y, i_req.up_x};

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_e_diff[i] <= {e_eye[i][DATA_W-1], e_eye[i]} - {e_tgt[i][DATA_W-1], e_tgt[i]};
            end
            r_e_eye <= e_eye;
            r_e_up  <= e_up;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) n1_in[i] = VEC_W'(signed'(r_e_diff[i]));
    end

    lvm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE1)
    ) u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_e_vld),
        .i_vec   (n1_in),
        .i_side  ({r_e_eye, r_e_up}),
        .o_valid (n1_vld),
        .o_vec   (n1_vec),
        .o_side  (n1_side)
    );

    assign {s1_eye, s1_up} = n1_side;

    // right = up x dir
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_dir[i] = n1_vec[i];
            c1_a[i]   = PW'(signed'(s1_up[i]));
            c1_b[i]   = PW'(n1_vec[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1_p[0] <= c1_a[1] * c1_b[2];
            r_c1_p[1] <= c1_a[2] * c1_b[1];
            r_c1_p[2] <= c1_a[2] * c1_b[0];
            r_c1_p[3] <= c1_a[0] * c1_b[2];
            r_c1_p[4] <= c1_a[0] * c1_b[1];
            r_c1_p[5] <= c1_a[1] * c1_b[0];
            r_c1_eye  <= s1_eye;
            r_c1_dir  <= n1_dir;
            r_c2_t[0] <= CW'(r_c1_p[0]) - CW'(r_c1_p[1]);
            r_c2_t[1] <= CW'(r_c1_p[2]) - CW'(r_c1_p[3]);
            r_c2_t[2] <= CW'(r_c1_p[4]) - CW'(r_c1_p[5]);
            r_c2_eye  <= r_c1_eye;
            r_c2_dir  <= r_c1_dir;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) n2_in[i] = VEC_W'(r_c2_t[i]);
    end

    lvm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE2)
    ) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c2_vld),
        .i_vec   (n2_in),
        .i_side  ({r_c2_eye, r_c2_dir}),
        .o_valid (n2_vld),
        .o_vec   (n2_vec),
        .o_side  (n2_side)
    );

    assign {s2_eye, s2_dir} = n2_side;

    // true up = dir x right
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_rt[i] = n2_vec[i];
            c3_a[i]  = PW2'(signed'(s2_dir[i]));
            c3_b[i]  = PW2'(n2_vec[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c3_p[0] <= c3_a[1] * c3_b[2];
            r_c3_p[1] <= c3_a[2] * c3_b[1];
            r_c3_p[2] <= c3_a[2] * c3_b[0];
            r_c3_p[3] <= c3_a[0] * c3_b[2];
            r_c3_p[4] <= c3_a[0] * c3_b[1];
            r_c3_p[5] <= c3_a[1] * c3_b[0];
            r_c3_eye  <= s2_eye;
            r_c3_dir  <= s2_dir;
            r_c3_rt   <= n2_rt;
            r_c4_t[0] <= CW2'(r_c3_p[0]) - CW2'(r_c3_p[1]);
            r_c4_t[1] <= CW2'(r_c3_p[2]) - CW2'(r_c3_p[3]);
            r_c4_t[2] <= CW2'(r_c3_p[4]) - CW2'(r_c3_p[5]);
            r_c4_eye  <= r_c3_eye;
            r_c4_dir  <= r_c3_dir;
            r_c4_rt   <= r_c3_rt;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) n3_in[i] = VEC_W'(r_c4_t[i]);
    end

    lvm_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE3)
    ) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c4_vld),
        .i_vec   (n3_in),
        .i_side  ({r_c4_eye, r_c4_dir, r_c4_rt}),
        .o_valid (n3_vld),
        .o_vec   (n3_vec),
        .o_side  (n3_side)
    );

    assign {s3_eye, s3_dir, s3_rt} = n3_side;

    always_comb begin
        for (int i = 0; i < 3; i++) n3_tu[i] = n3_vec[i];
        bas[0] = s3_rt;
        bas[1] = n3_tu;
        bas[2] = s3_dir;
    end

    // translation: basis . eye products, then sum, round, negate, saturate
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) begin
                    r_d1_p[r][i] <= PW'(signed'(bas[r][i])) * PW'(signed'(s3_eye[i]));
                end
            end
            r_d1_rt  <= s3_rt;
            r_d1_tu  <= n3_tu;
            r_d1_dir <= s3_dir;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            dsum[r] = DW'(r_d1_p[r][0]) + DW'(r_d1_p[r][1]) + DW'(r_d1_p[r][2]);
            dmag[r] = dsum[r][DW-1] ? unsigned'(-dsum[r]) : unsigned'(dsum[r]);
            drnd[r] = (dmag[r] + DOT_HALF) >> FRAC_BITS;
            if (dsum[r] > 0) begin
                d_tr[r] = (drnd[r] > SAT_N) ? DATA_W'(SAT_N) : DATA_W'(~drnd[r] + DW'(1));
            end else begin
                d_tr[r] = (drnd[r] > SAT_P) ? DATA_W'(SAT_P) : DATA_W'(drnd[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2_tr  <= d_tr;
            r_d2_rt  <= r_d1_rt;
            r_d2_tu  <= r_d1_tu;
            r_d2_dir <= r_d1_dir;
        end
    end

    // row sequencer: hold the matrix while its four rows go out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= ROW_FIRST;
        end else if (r_d2_vld && !i_stall) begin
            r_row <= r_row + ROW_W'(1);
        end
    end

    assign o_valid = r_d2_vld;

    always_comb begin
        o_res.row_index = r_row;
        o_res.last_row  = (r_row == ROW_LAST);
        if (r_row == ROW_LAST) begin
            o_res.col_0 = '0;
            o_res.col_1 = '0;
            o_res.col_2 = '0;
            o_res.col_3 = ONE;
        end else begin
            o_res.col_0 = DATA_W'(signed'(r_d2_rt[r_row]));
            o_res.col_1 = DATA_W'(signed'(r_d2_tu[r_row]));
            o_res.col_2 = DATA_W'(signed'(r_d2_dir[r_row]));
            o_res.col_3 = r_d2_tr[r_row];
        end
    end

    `LVM_ASSERT_NEXT(a_row_hold, o_valid && i_stall, o_valid && (r_row == $past(r_row)), "row moved while stalled")
    `LVM_ASSERT_NEXT(a_row_step, o_valid && !i_stall, r_row == ($past(r_row) + ROW_W'(1)), "row did not advance")
    `LVM_ASSERT_IMPL(a_stall_busy, o_stall, r_d2_vld && !(!i_stall && (r_row == ROW_LAST)), "stall without a pending matrix")
    `LVM_ASSERT_NEXT(a_mat_hold, o_valid && !(!i_stall && (r_row == ROW_LAST)), o_valid && $stable(r_d2_tr), "matrix changed mid-send")

endmodule
